@@ hw/rtl/qwts_pkg.sv @@
package qwts_pkg;

   // Sample and result width (Q12.4)
   localparam int SAMPLE_W = 16;
   // Width of the divider's step counter: one quotient bit per step
   localparam int QSTEP_W  = $clog2(SAMPLE_W);

   // Controller states, one-hot
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MAC  = 5'b00010,
      ST_PREP = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;      // take the request item
      logic mac_step;  // one multiply-accumulate over the window
      logic div_init;  // load divider with rounded dividend
      logic div_step;  // one quotient bit
      logic out_load;  // move quotient into the output register
   } ctrl_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic keep;      // current request item produces a result
      logic mac_last;  // current MAC step is the newest sample
      logic div_last;  // current divide step is the last one
      logic out_free;  // output register can take a new item
   } dp_status_type;

endpackage

@@ hw/rtl/qwts_ctrl.sv @@
module qwts_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  qwts_pkg::dp_status_type status,
   output qwts_pkg::ctrl_cmd_type  cmd
);
   import qwts_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      state_in  = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (status.keep) begin
                  state_in = ST_MAC;
               end
            end
         end
         ST_MAC: begin
            cmd.mac_step = 1'b1;
            if (status.mac_last) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.div_init = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hw/rtl/qwts_dp.sv @@
module qwts_dp #(
   parameter int WINDOW_LENGTH = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [qwts_pkg::SAMPLE_W-1:0]          req_sample_value,
   input  logic                                   req_track_start,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [qwts_pkg::SAMPLE_W-1:0]          rsp_smoothed_value,
   input  qwts_pkg::ctrl_cmd_type                 cmd,
   output qwts_pkg::dp_status_type                status
);
   import qwts_pkg::*;

   localparam int CNT_W   = $clog2(2 * WINDOW_LENGTH);
   localparam int CNT_MAX = 2 * WINDOW_LENGTH - 1;
   localparam int M_W     = $clog2(WINDOW_LENGTH + 1);
   localparam int IDX_W   = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
   localparam int W_W     = $clog2(WINDOW_LENGTH * WINDOW_LENGTH + 1);
   localparam int DEN_MAX = WINDOW_LENGTH * (WINDOW_LENGTH + 1) * (2 * WINDOW_LENGTH + 1) / 6;
   localparam int DEN_W   = $clog2(DEN_MAX + 1);
   localparam int NUM_W   = SAMPLE_W + DEN_W;
   localparam int PROD_W  = SAMPLE_W + W_W;

   logic [SAMPLE_W-1:0] win_ff [WINDOW_LENGTH];
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [IDX_W-1:0]    idx_ff;
   logic [M_W-1:0]      k_ff;
   logic [W_W-1:0]      w_ff;
   logic [NUM_W-1:0]    num_ff;
   logic [DEN_W-1:0]    den_ff;
   logic [NUM_W-1:0]    div_ff;
   logic [QSTEP_W-1:0]  qstep_ff;
   logic                rsp_valid_ff;
   logic [SAMPLE_W-1:0] rsp_value_ff;

   logic [CNT_W-1:0]    eff_count;
   logic [CNT_W-1:0]    m_diff;
   logic [M_W-1:0]      m_val;
   logic [PROD_W-1:0]   prod;
   logic [NUM_W-1:0]    dividend;
   logic [DEN_W:0]      trial;
   logic                ge;
   logic [DEN_W-1:0]    rem_next;

   // Track start restarts the count before the item is judged
   assign eff_count = req_track_start ? '0 : count_ff;
   assign count_in  = (eff_count < CNT_W'(CNT_MAX)) ? CNT_W'(eff_count + 1'b1) : eff_count;

   // Samples available in the window, capped at the window length
   assign m_diff = CNT_W'(eff_count - CNT_W'(WINDOW_LENGTH - 1));
   assign m_val  = (m_diff > CNT_W'(WINDOW_LENGTH)) ? M_W'(WINDOW_LENGTH) : M_W'(m_diff);

   assign prod     = PROD_W'(win_ff[idx_ff] * w_ff);
   assign dividend = num_ff + NUM_W'(den_ff >> 1);

   // Restoring divide: shift one dividend bit into the remainder
   assign trial    = {div_ff[NUM_W-1:SAMPLE_W], div_ff[SAMPLE_W-1]};
   assign ge       = (trial >= {1'b0, den_ff});
   assign rem_next = ge ? DEN_W'(trial - {1'b0, den_ff}) : DEN_W'(trial);

   assign status.keep     = (eff_count >= CNT_W'(WINDOW_LENGTH));
   assign status.mac_last = (idx_ff == '0);
   assign status.div_last = (qstep_ff == '0);
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.load) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && status.keep) begin
         for (int i = WINDOW_LENGTH - 1; i > 0; i--) begin
            win_ff[i] <= win_ff[i-1];
         end
         win_ff[0] <= req_sample_value;
         idx_ff    <= IDX_W'(m_val - 1'b1);
         k_ff      <= M_W'(1);
         w_ff      <= W_W'(1);
         num_ff    <= '0;
         den_ff    <= '0;
      end else if (cmd.mac_step) begin
         // Weights walk from oldest sample (1) up: (k+1)^2 = k^2 + 2k + 1
         num_ff <= num_ff + NUM_W'(prod);
         den_ff <= den_ff + DEN_W'(w_ff);
         w_ff   <= W_W'(w_ff + W_W'({k_ff, 1'b1}));
         k_ff   <= M_W'(k_ff + 1'b1);
         idx_ff <= IDX_W'(idx_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         div_ff   <= dividend;
         qstep_ff <= QSTEP_W'(SAMPLE_W - 1);
      end else if (cmd.div_step) begin
         div_ff   <= {rem_next, div_ff[SAMPLE_W-2:0], ge};
         qstep_ff <= QSTEP_W'(qstep_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_value_ff <= div_ff[SAMPLE_W-1:0];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_smoothed_value = rsp_value_ff;

endmodule

@@ hw/rtl/quadratic_weighted_trajectory_smoother.sv @@
// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_ready    req_sample_value[15:0], req_track_start
// rsp       out        rsp_valid/rsp_ready    rsp_smoothed_value[15:0]
//
// A discarded item (first WINDOW_LENGTH samples of a track) leaves the block idle.
// A kept item with m window samples passes through ST_MAC, ST_PREP and ST_DIV
// before its result is loaded: one serial multiply-accumulate per window
// sample, then a restoring divider that produces one quotient bit per cycle.
// Synchronous active-high reset clears the sample count and all handshakes.
// A stalled rsp holds its item; the next req item is taken meanwhile.
module quadratic_weighted_trajectory_smoother #(
   parameter int WINDOW_LENGTH = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [qwts_pkg::SAMPLE_W-1:0] req_sample_value,
   input  logic                          req_track_start,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [qwts_pkg::SAMPLE_W-1:0] rsp_smoothed_value
);
   import qwts_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // Sequence the item: accept, accumulate, divide, hand off
   qwts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Hold the window, count, accumulators, divider and output register
   qwts_dp #(
      .WINDOW_LENGTH (WINDOW_LENGTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_sample_value   (req_sample_value),
      .req_track_start    (req_track_start),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_smoothed_value (rsp_smoothed_value),
      .cmd                (cmd),
      .status             (status)
   );

   // Load the output register only when it is free
   a_out_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid || rsp_ready))
      else $error("result loaded over a pending item");

   // A discarded item leaves the block ready for the next one
   a_discard_ready: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !status.keep) |=> req_ready)
      else $error("discarded item started work");

   // Accumulate and divide never overlap
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(cmd.mac_step && (cmd.div_step || cmd.div_init)))
      else $error("accumulate and divide active together");

endmodule
